>>> src/s7d_pkg.sv
// Shared types, constants and the digit segment table for the seven-segment digit block.
// No dependencies.
`timescale 1ns / 1ps

package s7d_pkg;

  localparam int MAG_W = 14;
  localparam int RECIP_W = 17;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;
  localparam logic [6:0] MINUS_CODE = 7'h40;
  localparam logic [1:0] POS_MAX = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT,
    ST_SIGN
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic divide;
    logic emit_digit;
    logic emit_minus;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic pos_max;
    logic negative;
    logic out_free;
  } dp_status_t;

  function automatic logic [6:0] digit_segments(input logic [3:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'd0: seg = 7'h3F;
      4'd1: seg = 7'h06;
      4'd2: seg = 7'h5B;
      4'd3: seg = 7'h4F;
      4'd4: seg = 7'h66;
      4'd5: seg = 7'h6D;
      4'd6: seg = 7'h7D;
      4'd7: seg = 7'h07;
      4'd8: seg = 7'h7F;
      4'd9: seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

>>> src/s7d_datapath.sv
// Datapath: saturation, divide-by-ten step, digit decode and the output register.
// Depends on s7d_pkg.
`timescale 1ns / 1ps

module s7d_datapath
  import s7d_pkg::*;
#(
  parameter int SAT_HI = 9999,
  parameter int SAT_LO = -999
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] value,
  input  dp_cmd_t            cmd,
  output dp_status_t         sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         digit_position,
  output logic [6:0]         segments,
  output logic               last_digit
);

  localparam logic signed [16:0] HI_S = 17'(SAT_HI);
  localparam logic signed [16:0] LO_S = 17'(SAT_LO);

  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] quot;
  logic [1:0]       pos;
  logic             negative;

  logic signed [16:0]           value_ext;
  logic signed [16:0]           value_sat;
  logic signed [16:0]           value_abs;
  logic [MAG_W+RECIP_W-1:0]     product;
  logic [MAG_W-1:0]             quot_times_ten;
  logic [MAG_W-1:0]             remainder;

  always_comb begin
    value_ext = 17'(value);
    if (value_ext > HI_S) begin
      value_sat = HI_S;
    end else if (value_ext < LO_S) begin
      value_sat = LO_S;
    end else begin
      value_sat = value_ext;
    end
    value_abs = value_sat[16] ? -value_sat : value_sat;
  end

  assign product = mag * RECIP_TEN;
  assign quot_times_ten = MAG_W'({quot, 3'b000}) + MAG_W'({quot, 1'b0});
  assign remainder = mag - quot_times_ten;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= value_abs[MAG_W-1:0];
      negative <= value_sat[16];
      pos <= '0;
    end
    if (cmd.divide) begin
      quot <= MAG_W'(product[MAG_W+RECIP_W-1:RECIP_SHIFT]);
    end
    if (cmd.emit_digit) begin
      mag <= quot;
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_digit || cmd.emit_minus) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_digit) begin
      digit_position <= pos;
      segments <= digit_segments(remainder[3:0]);
      last_digit <= cmd.last;
    end else if (cmd.emit_minus) begin
      digit_position <= pos;
      segments <= MINUS_CODE;
      last_digit <= 1'b1;
    end
  end

  assign sts.quot_zero = (quot == '0);
  assign sts.pos_max = (pos == POS_MAX);
  assign sts.negative = negative;
  assign sts.out_free = !out_valid || out_ready;

endmodule

>>> src/s7d_controller.sv
// Controller state machine that sequences load, divide and digit emission.
// Depends on s7d_pkg.
`timescale 1ns / 1ps

module s7d_controller
  import s7d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          cmd.last = sts.pos_max || (sts.quot_zero && !sts.negative);
          if (cmd.last) begin
            state_next = ST_IDLE;
          end else if (sts.quot_zero) begin
            state_next = ST_SIGN;
          end else begin
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_minus = 1'b1;
          cmd.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/signed_number_to_seven_segment_digits.sv
// Top level: signed value in, stream of seven-segment digit items out.
// Depends on s7d_pkg, s7d_controller and s7d_datapath.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid, in_ready  | value
//   output  | out_valid, out_ready| digit_position, segments, last_digit
//
// Each digit takes a divide-by-ten step and then an emission into the output register, and a
// negative item ends with one more item for the minus sign.
// A new item is accepted once the last result of the previous one sits in the output register.
// A stalled output register holds the sequencer in place. Reset is synchronous and clears
// only the state machine and the output valid flag.
`timescale 1ns / 1ps

module signed_number_to_seven_segment_digits
  import s7d_pkg::*;
#(
  parameter int DIGIT_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         digit_position,
  output logic [6:0]         segments,
  output logic               last_digit
);

  localparam int EFF_DIGITS = (DIGIT_COUNT < 2) ? 2 : ((DIGIT_COUNT > 4) ? 4 : DIGIT_COUNT);
  localparam int SAT_HI = (10 ** EFF_DIGITS) - 1;
  localparam int SAT_LO = 1 - (10 ** (EFF_DIGITS - 1));

  dp_cmd_t    cmd;
  dp_status_t sts;

  s7d_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  s7d_datapath #(
    .SAT_HI (SAT_HI),
    .SAT_LO (SAT_LO)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .value          (value),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digit_position (digit_position),
    .segments       (segments),
    .last_digit     (last_digit)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while an item is in work");

  a_lit_segments: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> segments != 7'h00)
    else $error("output item with no lit segment");

  a_minus_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && segments == MINUS_CODE |-> last_digit)
    else $error("minus sign not on the final item");

  a_top_position_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_position == POS_MAX |-> last_digit)
    else $error("item at the top position not marked last");

endmodule
